// File: hdl/tvpt_pkg.sv
package tvpt_pkg;

  // field and register widths
  localparam int unsigned EntryW  = 18;
  localparam int unsigned PointW  = 20;
  localparam int unsigned RegW    = 54;
  localparam int unsigned CoordW  = 32;
  localparam int unsigned CfgIdxW = 2;

  // internal arithmetic widths
  localparam int unsigned FracIn   = 16;  // fraction bits of points and pose entries
  localparam int unsigned ProdW    = EntryW + PointW;  // pose entry times point
  localparam int unsigned RayW     = ProdW + 1;        // rotated ray term
  localparam int unsigned NumW     = ProdW + 1;        // numerator, Q.32
  localparam int unsigned DenW     = RayW + PointW;    // denominator, Q.48
  localparam int unsigned MagNW    = NumW - 2;         // numerator magnitude
  localparam int unsigned MagDW    = DenW - 1;         // denominator magnitude
  localparam int unsigned QuoW     = 47;               // quotient bits below the cap
  localparam int unsigned FracBits = 32;               // fraction bits produced by division
  localparam int unsigned OvfSh    = QuoW - FracBits;
  localparam int unsigned RatW     = QuoW + 2;         // signed ratio, cap included
  localparam int unsigned SumW     = RatW + 1;
  localparam int unsigned DepW     = QuoW + 1;         // depth magnitude
  localparam int unsigned HalfW    = DepW / 2;         // split of depth for the multipliers
  localparam int unsigned PartW    = PointW + HalfW;
  localparam int unsigned FullW    = PointW + DepW;
  localparam int unsigned ValW     = FullW - FracIn;

  localparam logic [RatW-1:0] RatioCap = RatW'(1) << QuoW;
  localparam logic [ValW-1:0] LimPos   = ValW'(32'h7FFF_FFFF);
  localparam logic [ValW-1:0] LimNeg   = ValW'(32'h8000_0000);

  // register reset values: identity rotation, zero translation
  localparam logic [RegW-1:0] RotXReset  = RegW'(1) << FracIn;
  localparam logic [RegW-1:0] RotYReset  = RegW'(1) << (EntryW + FracIn);
  localparam logic [RegW-1:0] RotZReset  = RegW'(1) << (2 * EntryW + FracIn);
  localparam logic [RegW-1:0] TransReset = '0;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ROT_X = 2'd0,
    CFG_ROT_Y = 2'd1,
    CFG_ROT_Z = 2'd2,
    CFG_TRANS = 2'd3
  } cfg_idx_e;

  // per-point side information carried along the pipeline
  typedef struct packed {
    logic signed [PointW-1:0] x1;
    logic signed [PointW-1:0] y1;
    logic                     deg;
    logic [1:0]               neg;
    logic [1:0]               ovf;
  } side_t;

  // one lane of the restoring divider
  typedef struct packed {
    logic [MagDW-1:0] rem;
    logic [MagDW-1:0] den;
    logic [MagNW-1:0] num;
    logic [QuoW-1:0]  quo;
  } div_lane_t;

  function automatic logic signed [EntryW-1:0] entry_of(input logic [RegW-1:0] r,
                                                        input int unsigned k);
    entry_of = r[EntryW*k +: EntryW];
  endfunction

endpackage

// File: hdl/two_view_point_triangulation.sv
// Two-view point triangulation, fully pipelined.
// Configuration: write channel cfg_valid_i/cfg_ready_o with cfg_index_i selecting
// rotation row x, y, z or the packed translation; cfg_ready_o is always high.
// Write it only while no request is in flight.
// Input: one point correspondence per request on in_valid_i/in_ready_o.
// Output: the negated 3D point plus degenerate and clipped flags on
// out_valid_o/out_ready_i.
// The pipeline has five stages of products and sums, one divider setup
// stage, 47 restoring divider stages (one quotient bit each, both depth ratios
// in parallel lanes) and eight stages for mean, scaling and saturation.
// Throughput is one request per cycle. When the receiver holds out_ready_i low
// while a result waits, the whole pipeline holds and in_ready_o drops; nothing
// is lost or repeated. Bubbles travel as cleared valid bits.
// Reset clears all valid bits and loads the identity rotation and a zero
// translation.
module two_view_point_triangulation (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic [tvpt_pkg::CfgIdxW-1:0]            cfg_index_i,
  input  logic [tvpt_pkg::RegW-1:0]               cfg_data_i,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic signed [tvpt_pkg::PointW-1:0]      first_x_i,
  input  logic signed [tvpt_pkg::PointW-1:0]      first_y_i,
  input  logic signed [tvpt_pkg::PointW-1:0]      second_x_i,
  input  logic signed [tvpt_pkg::PointW-1:0]      second_y_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic signed [tvpt_pkg::CoordW-1:0]      point_x_o,
  output logic signed [tvpt_pkg::CoordW-1:0]      point_y_o,
  output logic signed [tvpt_pkg::CoordW-1:0]      point_z_o,
  output logic                                    degenerate_o,
  output logic                                    clipped_o
);
  import tvpt_pkg::*;

  // configuration registers
  logic [RegW-1:0] rot_x_q, rot_y_q, rot_z_q, trans_q;

  logic signed [EntryW-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22, tx, ty, tz;

  logic adv;

  // front stages
  logic [5:1]               fv_q;
  side_t                    s1_side_q, s2_side_q, s3_side_q, s4_side_q, s5_side_q;
  side_t                    s5_side_d;
  logic signed [ProdW-1:0]  s1_m_q [6];
  logic signed [ProdW-1:0]  s1_nx_q, s1_ny_q;
  logic signed [PointW-1:0] s1_x2_q, s1_y2_q, s2_x2_q, s2_y2_q;
  logic signed [RayW-1:0]   s2_rx_q, s2_ry_q, s2_rz_q, s3_rx_q, s3_ry_q;
  logic signed [NumW-1:0]   s2_num_q [2];
  logic signed [NumW-1:0]   s3_num_q [2];
  logic signed [NumW-1:0]   s4_num_q [2];
  logic signed [DenW-1:0]   s3_px_q, s3_py_q;
  logic signed [DenW-1:0]   s4_den_q [2];
  logic [MagNW-1:0]         s5_n_q [2];
  logic [MagDW-1:0]         s5_d_q [2];
  logic signed [NumW-1:0]   num_abs [2];
  logic signed [DenW-1:0]   den_abs [2];

  // divider pipeline
  div_lane_t dv_q      [QuoW+1][2];
  side_t     dv_side_q [QuoW+1];
  side_t     dv_side_d;
  logic      dv_v_q    [QuoW+1];

  // back stages
  logic [7:1]               bv_q;
  logic [RatW-1:0]          rmag [2];
  logic signed [RatW-1:0]   d1_rat_q [2];
  logic signed [SumW-1:0]   d2_sum_q;
  logic signed [SumW-1:0]   sum_adj, sum_half;
  logic signed [RatW-1:0]   d3_dep_q;
  logic signed [RatW-1:0]   dep_abs;
  logic signed [PointW-1:0] x1_abs, y1_abs;
  side_t                    d1_side_q, d2_side_q, d3_side_q;
  logic [7:1]               bdeg_q;
  logic [7:1]               bsat_q;
  logic [DepW-1:0]          d4_dm_q;
  logic [PointW-1:0]        d4_m_q [2];
  logic [2:0]               d4_neg_q, d5_neg_q, d6_neg_q, d7_neg_q;
  logic [PartW-1:0]         d5_lo_q [2];
  logic [PartW-1:0]         d5_hi_q [2];
  logic [DepW-1:0]          d5_dm_q;
  logic [ValW-1:0]          d6_v_q [3];
  logic [FullW-1:0]         prod_full [2];
  logic [ValW-1:0]          lim [3];
  logic [2:0]               d7_sat_q;
  logic [CoordW-1:0]        d7_c_q [3];
  logic                     out_valid_q, degenerate_q, clipped_q;
  logic signed [CoordW-1:0] point_x_q, point_y_q, point_z_q;

  assign r00 = entry_of(rot_x_q, 0);
  assign r01 = entry_of(rot_x_q, 1);
  assign r02 = entry_of(rot_x_q, 2);
  assign r10 = entry_of(rot_y_q, 0);
  assign r11 = entry_of(rot_y_q, 1);
  assign r12 = entry_of(rot_y_q, 2);
  assign r20 = entry_of(rot_z_q, 0);
  assign r21 = entry_of(rot_z_q, 1);
  assign r22 = entry_of(rot_z_q, 2);
  assign tx  = entry_of(trans_q, 0);
  assign ty  = entry_of(trans_q, 1);
  assign tz  = entry_of(trans_q, 2);

  assign cfg_ready_o = 1'b1;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_x_q <= RotXReset;
      rot_y_q <= RotYReset;
      rot_z_q <= RotZReset;
      trans_q <= TransReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ROT_X: rot_x_q <= cfg_data_i;
        CFG_ROT_Y: rot_y_q <= cfg_data_i;
        CFG_ROT_Z: rot_z_q <= cfg_data_i;
        CFG_TRANS: trans_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // global advance: the pipeline holds only while a result waits unread
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  // valid bits of the front and back stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q        <= '0;
      bv_q        <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      fv_q        <= {fv_q[4:1], in_valid_i};
      bv_q        <= {bv_q[6:1], dv_v_q[QuoW]};
      out_valid_q <= bv_q[7];
    end
  end

  // stage 1: pose entries times point coordinates
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_side_q <= '{x1: first_x_i, y1: first_y_i, deg: 1'b0, neg: 2'b00, ovf: 2'b00};
      s1_m_q[0] <= r00 * first_x_i;
      s1_m_q[1] <= r01 * first_y_i;
      s1_m_q[2] <= r10 * first_x_i;
      s1_m_q[3] <= r11 * first_y_i;
      s1_m_q[4] <= r20 * first_x_i;
      s1_m_q[5] <= r21 * first_y_i;
      s1_nx_q   <= second_x_i * tz;
      s1_ny_q   <= second_y_i * tz;
      s1_x2_q   <= second_x_i;
      s1_y2_q   <= second_y_i;
    end
  end

  // stage 2: rotated ray and numerators
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_side_q   <= s1_side_q;
      s2_rx_q     <= RayW'(s1_m_q[0]) + RayW'(s1_m_q[1]) + (RayW'(r02) <<< FracIn);
      s2_ry_q     <= RayW'(s1_m_q[2]) + RayW'(s1_m_q[3]) + (RayW'(r12) <<< FracIn);
      s2_rz_q     <= RayW'(s1_m_q[4]) + RayW'(s1_m_q[5]) + (RayW'(r22) <<< FracIn);
      s2_num_q[0] <= NumW'(s1_nx_q) - (NumW'(tx) <<< FracIn);
      s2_num_q[1] <= NumW'(s1_ny_q) - (NumW'(ty) <<< FracIn);
      s2_x2_q     <= s1_x2_q;
      s2_y2_q     <= s1_y2_q;
    end
  end

  // stage 3: second-view coordinate times depth row
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_side_q <= s2_side_q;
      s3_px_q   <= s2_x2_q * s2_rz_q;
      s3_py_q   <= s2_y2_q * s2_rz_q;
      s3_rx_q   <= s2_rx_q;
      s3_ry_q   <= s2_ry_q;
      s3_num_q  <= s2_num_q;
    end
  end

  // stage 4: denominators
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_side_q   <= s3_side_q;
      s4_den_q[0] <= s3_px_q - (DenW'(s3_rx_q) <<< FracIn);
      s4_den_q[1] <= s3_py_q - (DenW'(s3_ry_q) <<< FracIn);
      s4_num_q    <= s3_num_q;
    end
  end

  // stage 5: magnitudes, quotient signs, zero denominator
  always_comb begin
    s5_side_d     = s4_side_q;
    s5_side_d.deg = (s4_den_q[0] == '0) || (s4_den_q[1] == '0);
    for (int l = 0; l < 2; l++) begin
      num_abs[l]       = s4_num_q[l][NumW-1] ? -s4_num_q[l] : s4_num_q[l];
      den_abs[l]       = s4_den_q[l][DenW-1] ? -s4_den_q[l] : s4_den_q[l];
      s5_side_d.neg[l] = s4_num_q[l][NumW-1] ^ s4_den_q[l][DenW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s5_side_q <= s5_side_d;
      for (int l = 0; l < 2; l++) begin
        s5_n_q[l] <= num_abs[l][MagNW-1:0];
        s5_d_q[l] <= den_abs[l][MagDW-1:0];
      end
    end
  end

  // divider setup: cap check and initial partial remainder
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_v_q[0] <= 1'b0;
    end else if (adv) begin
      dv_v_q[0] <= fv_q[5];
    end
  end

  always_comb begin
    dv_side_d = s5_side_q;
    for (int l = 0; l < 2; l++) begin
      dv_side_d.ovf[l] = (MagDW + OvfSh)'(s5_n_q[l]) >= {s5_d_q[l], {OvfSh{1'b0}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_side_q[0] <= dv_side_d;
      for (int l = 0; l < 2; l++) begin
        dv_q[0][l].rem <= MagDW'(s5_n_q[l] >> OvfSh);
        dv_q[0][l].den <= s5_d_q[l];
        dv_q[0][l].num <= s5_n_q[l];
        dv_q[0][l].quo <= '0;
      end
    end
  end

  // restoring division, one quotient bit per stage, two lanes
  for (genvar s = 0; s < QuoW; s++) begin : g_div
    localparam int K = QuoW - 1 - s;

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic           nbit;
      logic [MagDW:0] trial;
      logic [MagDW:0] diff;

      if (K >= FracBits) begin : g_bit
        assign nbit = dv_q[s][l].num[K-FracBits];
      end else begin : g_zero
        assign nbit = 1'b0;
      end

      assign trial = {dv_q[s][l].rem, nbit};
      assign diff  = trial - {1'b0, dv_q[s][l].den};

      always_ff @(posedge clk_i) begin
        if (adv) begin
          dv_q[s+1][l].rem <= diff[MagDW] ? trial[MagDW-1:0] : diff[MagDW-1:0];
          dv_q[s+1][l].den <= dv_q[s][l].den;
          dv_q[s+1][l].num <= dv_q[s][l].num;
          dv_q[s+1][l].quo <= {dv_q[s][l].quo[QuoW-2:0], !diff[MagDW]};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[s+1] <= 1'b0;
      end else if (adv) begin
        dv_v_q[s+1] <= dv_v_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_side_q[s+1] <= dv_side_q[s];
      end
    end
  end

  // back stage 1: capped and signed ratios
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      rmag[l] = dv_side_q[QuoW].ovf[l] ? RatioCap : RatW'(dv_q[QuoW][l].quo);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d1_side_q <= dv_side_q[QuoW];
      for (int l = 0; l < 2; l++) begin
        d1_rat_q[l] <= dv_side_q[QuoW].neg[l] ? -rmag[l] : rmag[l];
      end
    end
  end

  // back stage 2: sum of the two ratios
  always_ff @(posedge clk_i) begin
    if (adv) begin
      d2_side_q <= d1_side_q;
      d2_sum_q  <= SumW'(d1_rat_q[0]) + SumW'(d1_rat_q[1]);
    end
  end

  // back stage 3: halve, rounding toward zero
  always_comb begin
    sum_adj  = d2_sum_q + $signed(SumW'(d2_sum_q[SumW-1] & d2_sum_q[0]));
    sum_half = sum_adj >>> 1;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d3_side_q <= d2_side_q;
      d3_dep_q  <= sum_half[RatW-1:0];
    end
  end

  // back stage 4: magnitudes and output signs
  always_comb begin
    dep_abs = d3_dep_q[RatW-1] ? -d3_dep_q : d3_dep_q;
    x1_abs  = d3_side_q.x1[PointW-1] ? -d3_side_q.x1 : d3_side_q.x1;
    y1_abs  = d3_side_q.y1[PointW-1] ? -d3_side_q.y1 : d3_side_q.y1;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d4_dm_q     <= dep_abs[DepW-1:0];
      d4_m_q[0]   <= x1_abs;
      d4_m_q[1]   <= y1_abs;
      d4_neg_q[0] <= !(d3_side_q.x1[PointW-1] ^ d3_dep_q[RatW-1]);
      d4_neg_q[1] <= !(d3_side_q.y1[PointW-1] ^ d3_dep_q[RatW-1]);
      d4_neg_q[2] <= !d3_dep_q[RatW-1];
    end
  end

  // flags that ride the back stages
  always_ff @(posedge clk_i) begin
    if (adv) begin
      bdeg_q <= {bdeg_q[6:4], d3_side_q.deg, d2_side_q.deg, d1_side_q.deg,
                 dv_side_q[QuoW].deg};
      bsat_q <= {bsat_q[6:1], |dv_side_q[QuoW].ovf};
    end
  end

  // back stage 5: partial products of ray component and depth
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int c = 0; c < 2; c++) begin
        d5_lo_q[c] <= d4_m_q[c] * d4_dm_q[HalfW-1:0];
        d5_hi_q[c] <= d4_m_q[c] * d4_dm_q[DepW-1:HalfW];
      end
      d5_dm_q  <= d4_dm_q;
      d5_neg_q <= d4_neg_q;
    end
  end

  // back stage 6: combine partial products, drop fraction bits
  always_comb begin
    for (int c = 0; c < 2; c++) begin
      prod_full[c] = {d5_hi_q[c], {HalfW{1'b0}}} + FullW'(d5_lo_q[c]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d6_v_q[0] <= prod_full[0][FullW-1:FracIn];
      d6_v_q[1] <= prod_full[1][FullW-1:FracIn];
      d6_v_q[2] <= ValW'(d5_dm_q);
      d6_neg_q  <= d5_neg_q;
    end
  end

  // back stage 7: saturate magnitudes
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      lim[c] = d6_neg_q[c] ? LimNeg : LimPos;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        d7_sat_q[c] <= d6_v_q[c] > lim[c];
        d7_c_q[c]   <= (d6_v_q[c] > lim[c]) ? lim[c][CoordW-1:0] : d6_v_q[c][CoordW-1:0];
      end
      d7_neg_q <= d6_neg_q;
    end
  end

  // output register: apply sign, zero on degenerate input
  always_ff @(posedge clk_i) begin
    if (adv) begin
      degenerate_q <= bdeg_q[7];
      clipped_q    <= !bdeg_q[7] && (bsat_q[7] || (|d7_sat_q));
      point_x_q    <= bdeg_q[7] ? '0 : (d7_neg_q[0] ? -d7_c_q[0] : d7_c_q[0]);
      point_y_q    <= bdeg_q[7] ? '0 : (d7_neg_q[1] ? -d7_c_q[1] : d7_c_q[1]);
      point_z_q    <= bdeg_q[7] ? '0 : (d7_neg_q[2] ? -d7_c_q[2] : d7_c_q[2]);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign degenerate_o = degenerate_q;
  assign clipped_o    = clipped_q;
  assign point_x_o    = point_x_q;
  assign point_y_o    = point_y_q;
  assign point_z_o    = point_z_q;

endmodule

// File: test/two_view_point_triangulation_tb.sv
`timescale 1ns / 100ps

module two_view_point_triangulation_tb;
  import tvpt_pkg::*;

  localparam int unsigned StallLimit = 20000;
  localparam int unsigned DrainCycles = 80;

  typedef struct packed {
    logic signed [PointW-1:0] x1;
    logic signed [PointW-1:0] y1;
    logic signed [PointW-1:0] x2;
    logic signed [PointW-1:0] y2;
  } corr_t;

  typedef struct packed {
    logic [CoordW-1:0] px;
    logic [CoordW-1:0] py;
    logic [CoordW-1:0] pz;
    logic              deg;
    logic              clip;
  } point_t;

  logic clk, rst_n;
  logic cfg_valid, cfg_ready;
  cfg_idx_e cfg_index;
  logic [RegW-1:0] cfg_data;
  logic in_valid, in_ready;
  logic signed [PointW-1:0] first_x, first_y, second_x, second_y;
  logic out_valid, out_ready;
  logic signed [CoordW-1:0] point_x, point_y, point_z;
  logic degenerate, clipped;

  // predictor copy of the pose registers
  logic [RegW-1:0] pose_rot [3];
  logic [RegW-1:0] pose_trans;

  corr_t  pending_q[$];
  point_t expected_q[$];
  int unsigned send_idle_pct, recv_stall_pct;
  int unsigned quiet_cycles;
  bit failed;

  two_view_point_triangulation i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .first_x_i    (first_x),
    .first_y_i    (first_y),
    .second_x_i   (second_x),
    .second_y_i   (second_y),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .point_x_o    (point_x),
    .point_y_o    (point_y),
    .point_z_o    (point_z),
    .degenerate_o (degenerate),
    .clipped_o    (clipped)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic logic signed [63:0] pose_entry(logic [RegW-1:0] r, int k);
    logic signed [EntryW-1:0] e;
    e = r[EntryW*k +: EntryW];
    return 64'(e);
  endfunction

  function automatic logic [63:0] magnitude(logic signed [63:0] v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  // depth ratio in Q.16 with magnitude capped at 2^47
  function automatic logic signed [63:0] depth_ratio(logic signed [63:0] num,
                                                     logic signed [63:0] den,
                                                     inout bit sat);
    logic [63:0] n, d, q, r, cap;
    bit neg;
    n = magnitude(num);
    d = magnitude(den);
    cap = 64'd1 << 47;
    q = n / d;
    r = n % d;
    neg = (num < 0) != (den < 0);
    if (q >= cap) begin
      q = cap;
      sat = 1'b1;
    end else begin
      for (int i = 0; i < 32; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= d) begin
          r = r - d;
          q[0] = 1'b1;
        end
        if (q >= cap) begin
          q = cap;
          sat = 1'b1;
          break;
        end
      end
    end
    return neg ? -$signed(q) : $signed(q);
  endfunction

  // negated, saturated coordinate of ray component times depth
  function automatic logic [CoordW-1:0] scaled_coord(logic signed [63:0] p,
                                                     logic signed [63:0] dep,
                                                     inout bit sat);
    logic [127:0] prod;
    logic [63:0] v, lim;
    bit neg;
    neg = !((p < 0) != (dep < 0));
    lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    prod = 128'(magnitude(p)) * 128'(magnitude(dep));
    prod = prod >> 16;
    if (prod > 128'(lim)) begin
      v = lim;
      sat = 1'b1;
    end else begin
      v = prod[63:0];
    end
    return neg ? CoordW'(-v) : CoordW'(v);
  endfunction

  function automatic point_t triangulate(corr_t c);
    logic signed [63:0] x1, y1, x2, y2, ray_x, ray_y, ray_z;
    logic signed [63:0] den1, den2, num1, num2, depth;
    point_t res;
    bit sat;
    x1 = 64'(c.x1);
    y1 = 64'(c.y1);
    x2 = 64'(c.x2);
    y2 = 64'(c.y2);
    sat = 1'b0;
    ray_x = pose_entry(pose_rot[CFG_ROT_X], 0) * x1 + pose_entry(pose_rot[CFG_ROT_X], 1) * y1
          + pose_entry(pose_rot[CFG_ROT_X], 2) * 65536;
    ray_y = pose_entry(pose_rot[CFG_ROT_Y], 0) * x1 + pose_entry(pose_rot[CFG_ROT_Y], 1) * y1
          + pose_entry(pose_rot[CFG_ROT_Y], 2) * 65536;
    ray_z = pose_entry(pose_rot[CFG_ROT_Z], 0) * x1 + pose_entry(pose_rot[CFG_ROT_Z], 1) * y1
          + pose_entry(pose_rot[CFG_ROT_Z], 2) * 65536;
    den1 = x2 * ray_z - ray_x * 65536;
    den2 = y2 * ray_z - ray_y * 65536;
    num1 = x2 * pose_entry(pose_trans, 2) - pose_entry(pose_trans, 0) * 65536;
    num2 = y2 * pose_entry(pose_trans, 2) - pose_entry(pose_trans, 1) * 65536;
    res = '0;
    if (den1 == 0 || den2 == 0) begin
      res.deg = 1'b1;
      return res;
    end
    depth = depth_ratio(num1, den1, sat) + depth_ratio(num2, den2, sat);
    depth = depth / 2;
    res.px = scaled_coord(x1, depth, sat);
    res.py = scaled_coord(y1, depth, sat);
    res.pz = scaled_coord(64'sd65536, depth, sat);
    res.clip = sat;
    return res;
  endfunction

  // request driver
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      first_x  <= '0;
      first_y  <= '0;
      second_x <= '0;
      second_y <= '0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) expected_q.push_back(triangulate({first_x, first_y, second_x, second_y}));
      if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        corr_t c;
        c = pending_q.pop_front();
        in_valid <= 1'b1;
        first_x  <= c.x1;
        first_y  <= c.y1;
        second_x <= c.x2;
        second_y <= c.y2;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor and stall control
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        point_t got, exp_p;
        got = {point_x, point_y, point_z, degenerate, clipped};
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          failed = 1'b1;
        end else begin
          exp_p = expected_q.pop_front();
          if (got.px !== exp_p.px) begin
            $display("%0t: point_x expected %h actual %h", $time, exp_p.px, got.px);
            failed = 1'b1;
          end
          if (got.py !== exp_p.py) begin
            $display("%0t: point_y expected %h actual %h", $time, exp_p.py, got.py);
            failed = 1'b1;
          end
          if (got.pz !== exp_p.pz) begin
            $display("%0t: point_z expected %h actual %h", $time, exp_p.pz, got.pz);
            failed = 1'b1;
          end
          if (got.deg !== exp_p.deg) begin
            $display("%0t: degenerate expected %b actual %b", $time, exp_p.deg, got.deg);
            failed = 1'b1;
          end
          if (got.clip !== exp_p.clip) begin
            $display("%0t: clipped expected %b actual %b", $time, exp_p.clip, got.clip);
            failed = 1'b1;
          end
        end
      end
      out_ready <= $urandom_range(99) >= recv_stall_pct;
    end
  end

  // watchdog on accepted requests, results and configuration writes
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_valid) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  function automatic logic [PointW-1:0] rand_point();
    case ($urandom_range(3))
      0: return PointW'($urandom);
      1: return PointW'($signed($urandom_range(131072)) - 65536);
      2: return PointW'($signed($urandom_range(16384)) - 8192);
      default: return $urandom_range(1) ? 20'h7FFFF : 20'h80000;
    endcase
  endfunction

  function automatic logic [EntryW-1:0] rand_entry();
    case ($urandom_range(3))
      0: return EntryW'($urandom);
      1: return EntryW'($signed($urandom_range(131072)) - 65536);
      2: return EntryW'(0);
      default: return $urandom_range(1) ? 18'h1FFFF : 18'h20000;
    endcase
  endfunction

  task automatic write_reg(cfg_idx_e idx, logic [RegW-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_TRANS) pose_trans = data;
    else pose_rot[idx] = data;
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || in_valid || expected_q.size() > 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic queue_random(int n);
    repeat (n) begin
      corr_t c;
      c.x1 = rand_point();
      c.y1 = rand_point();
      c.x2 = rand_point();
      c.y2 = rand_point();
      if ($urandom_range(9) == 0) c.x2 = c.x1;
      if ($urandom_range(9) == 0) c.y2 = c.y1;
      pending_q.push_back(c);
    end
  endtask

  initial begin
    failed = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    cfg_valid = 1'b0;
    cfg_index = CFG_ROT_X;
    cfg_data = '0;
    pose_rot[CFG_ROT_X] = RotXReset;
    pose_rot[CFG_ROT_Y] = RotYReset;
    pose_rot[CFG_ROT_Z] = RotZReset;
    pose_trans = TransReset;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset pose gives zero numerators, identity gives zero denominators where x2 equals x1 and y2 equals y1
    pending_q.push_back({20'sd65536, 20'sd0, 20'sd65536, 20'sd0});
    pending_q.push_back({20'sd1000, 20'sd2000, 20'sd5000, 20'sd7000});
    drain();
    write_reg(CFG_TRANS, {18'sd0, 18'sd0, 18'sd65536});
    write_reg(CFG_ROT_X, {18'sd0, 18'h1FFFF, 18'h20000});
    pending_q.push_back({20'h7FFFF, 20'h7FFFF, 20'h80000, 20'h80000});
    pending_q.push_back({20'h80000, 20'h80000, 20'h7FFFF, 20'h7FFFF});
    pending_q.push_back({20'sd0, 20'sd0, 20'sd0, 20'sd0});
    pending_q.push_back({20'sd1, 20'sd1, 20'sd3, 20'sd65536});
    pending_q.push_back({20'sd65536, 20'sd65536, 20'sd65537, 20'sd65535});
    drain();
    write_reg(CFG_TRANS, {18'h1FFFF, 18'h20000, 18'h1FFFF});
    write_reg(CFG_ROT_Y, {18'h20000, 18'h20000, 18'h20000});
    write_reg(CFG_ROT_Z, {18'h1FFFF, 18'h1FFFF, 18'h1FFFF});
    pending_q.push_back({20'h7FFFF, 20'h80000, 20'h7FFFF, 20'h80000});
    pending_q.push_back({20'sd1, 20'sd0, 20'sd0, 20'sd1});
    pending_q.push_back({20'h80000, 20'h7FFFF, 20'h80000, 20'h7FFFF});
    drain();

    // random phases with fresh pose and different idling
    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      if (phase == 7) begin
        write_reg(CFG_ROT_X, RotXReset);
        write_reg(CFG_ROT_Y, RotYReset);
        write_reg(CFG_ROT_Z, RotZReset);
        write_reg(CFG_TRANS, {18'h1FFFF, 18'h20000, 18'h1FFFF});
      end else begin
        write_reg(CFG_ROT_X, {rand_entry(), rand_entry(), rand_entry()});
        write_reg(CFG_ROT_Y, {rand_entry(), rand_entry(), rand_entry()});
        write_reg(CFG_ROT_Z, {rand_entry(), rand_entry(), rand_entry()});
        write_reg(CFG_TRANS, {rand_entry(), rand_entry(), rand_entry()});
      end
      queue_random(235);
      drain();
    end

    if (!failed) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
